/* hw/rtl/kdpt_pkg.sv */
`timescale 1ns / 1ps

package kdpt_pkg;

  localparam int CFG_W  = 32;
  localparam int CFG_AW = 3;

  localparam logic REG_LONG_PRESS = 1'b0;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 32'd500;

  localparam logic [1:0] ST_UP      = 2'd0;
  localparam logic [1:0] ST_FALLING = 2'd1;
  localparam logic [1:0] ST_DOWN    = 2'd2;
  localparam logic [1:0] ST_RISING  = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef logic [1:0] key_state_t;

  typedef struct packed {
    logic [FIFO_AW:0] used;
    logic             not_empty;
  } fifo_stat_t;

endpackage

/* hw/rtl/kdpt_out_fifo.sv */
`timescale 1ns / 1ps

module kdpt_out_fifo
  import kdpt_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output fifo_stat_t        stat
);

  logic [DATA_W-1:0]  mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   used_r;
  logic [FIFO_AW:0]   used_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (push && !pop) begin
      used_nxt = used_r + 1'b1;
    end else if (pop && !push) begin
      used_nxt = used_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      used_r <= used_nxt;
    end
  end

  assign pop_data       = mem_r[rd_ptr_r];
  assign stat.used      = used_r;
  assign stat.not_empty = (used_r != '0);

endmodule

/* hw/rtl/key_debounce_press_timer.sv */
`timescale 1ns / 1ps
// key debounce with press-duration timer
// in_*: one sample word per key: key number, raw level (0 pressed) and tick count.
// each key steps through up, falling, down, rising; two agreeing samples accept
// a press or a release. an accepted press stores its tick, an accepted release
// sends one out_* word with key, release tick, wrapped press duration and a
// start marker that is raised once, on the first release longer than
// long_press_ticks (apb register at byte address 0, reset value 500).
// throughput: one sample word per cycle while in_tready is high. per-key state sits in a small ram
// that is read when a word is taken and written back the next cycle; a
// same-key word right behind it gets the written-back entry forwarded.
// a release word is pushed from the read stage into the output queue, in order.
// samples that cause no release produce no output word.
// a four-word output queue holds results while out_tready is low; in_tready
// drops only when every queue slot is spoken for by queued or in-flight words.
// reset (synchronous, active low) puts all keys up, press ticks at all ones,
// the marker armed and the threshold at 500; no clearing pass is needed, the
// block takes samples in the first cycle after reset.
module key_debounce_press_timer
  import kdpt_pkg::*;
#(
  parameter int NUM_KEYS   = 4,
  parameter int TICK_WIDTH = 32,
  localparam int KW        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1,
  localparam int IN_W      = KW + 1 + TICK_WIDTH,
  localparam int IN_TW     = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W     = KW + 2 * TICK_WIDTH + 1,
  localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // key_index, key_level, tick_now
  input  logic [IN_TW-1:0]    in_tdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // released_key, release_tick, press_ticks, start_marker
  output logic [OUT_TW-1:0]   out_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_W-1:0]    pwdata,
  output logic [CFG_W-1:0]    prdata,
  output logic                pready
);

  localparam int ENT_W  = TICK_WIDTH + 2;
  localparam int CMP_W  = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

  localparam logic [ENT_W-1:0] ENT_RESET = {ST_UP, {TICK_WIDTH{1'b1}}};

  logic [KW-1:0]         in_key;
  logic                  in_level;
  logic [TICK_WIDTH-1:0] in_tick;
  logic                  in_acc;
  logic                  in_hit;

  logic [CFG_W-1:0]      long_press_r;
  logic                  cfg_wr;

  logic [ENT_W-1:0]      mem_r [NUM_KEYS];
  logic [NUM_KEYS-1:0]   ent_vld_r;
  logic [ENT_W-1:0]      rd_ent_r;
  logic                  rd_vld_r;

  logic                  s1_valid_r;
  logic                  s1_hit_r;
  logic [KW-1:0]         s1_key_r;
  logic                  s1_level_r;
  logic [TICK_WIDTH-1:0] s1_tick_r;

  logic                  wb_vld_r;
  logic [KW-1:0]         wb_key_r;
  logic [ENT_W-1:0]      wb_ent_r;

  logic                  armed_r;

  logic [ENT_W-1:0]      cur_ent;
  key_state_t            cur_st;
  logic [TICK_WIDTH-1:0] cur_tick;
  key_state_t            nxt_st;
  logic [TICK_WIDTH-1:0] nxt_tick;
  logic                  release_hit;
  logic [TICK_WIDTH-1:0] dur;
  logic                  fire;
  logic                  wr_en;
  logic [ENT_W-1:0]      wr_ent;
  logic                  res_push;
  logic [OUT_W-1:0]      res_data;
  logic [OUT_W-1:0]      fifo_q;
  logic                  fifo_pop;
  fifo_stat_t            fifo_stat;

  assign in_key   = in_tdata[KW-1:0];
  assign in_level = in_tdata[KW];
  assign in_tick  = in_tdata[KW+1 +: TICK_WIDTH];
  assign in_acc   = in_tvalid && in_tready;
  assign in_hit   = ({1'b0, in_key} < (KW+1)'(NUM_KEYS));

  // slots in the output queue cover queued words, the word in flight and a new one
  assign in_tready = (({1'b0, fifo_stat.used} + (FIFO_AW+2)'(s1_valid_r))
                      < (FIFO_AW+2)'(FIFO_DEPTH));

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LONG_PRESS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RESET;
    end else if (cfg_wr) begin
      long_press_r <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LONG_PRESS) begin
      prdata = long_press_r;
    end
  end

  // per-key state ram
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[s1_key_r] <= wr_ent;
    end
    if (in_acc && in_hit) begin
      rd_ent_r <= mem_r[in_key];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_r[s1_key_r] <= 1'b1;
      end
      if (in_acc && in_hit) begin
        rd_vld_r <= ent_vld_r[in_key];
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_hit_r   <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s1_hit_r   <= in_acc && in_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_key_r   <= in_key;
      s1_level_r <= in_level;
      s1_tick_r  <= in_tick;
    end
  end

  // forward last write-back when the same key follows right behind
  always_comb begin
    if (wb_vld_r && (wb_key_r == s1_key_r)) begin
      cur_ent = wb_ent_r;
    end else if (rd_vld_r) begin
      cur_ent = rd_ent_r;
    end else begin
      cur_ent = ENT_RESET;
    end
  end

  assign cur_st   = cur_ent[ENT_W-1 -: 2];
  assign cur_tick = cur_ent[TICK_WIDTH-1:0];

  always_comb begin
    nxt_st      = cur_st;
    nxt_tick    = cur_tick;
    release_hit = 1'b0;
    unique case (cur_st)
      ST_UP: begin
        if (!s1_level_r) begin
          nxt_st = ST_FALLING;
        end
      end
      ST_FALLING: begin
        if (!s1_level_r) begin
          nxt_st   = ST_DOWN;
          nxt_tick = s1_tick_r;
        end else begin
          nxt_st = ST_UP;
        end
      end
      ST_DOWN: begin
        if (s1_level_r) begin
          nxt_st = ST_RISING;
        end
      end
      ST_RISING: begin
        if (!s1_level_r) begin
          nxt_st = ST_DOWN;
        end else begin
          nxt_st      = ST_UP;
          release_hit = 1'b1;
        end
      end
    endcase
  end

  assign dur      = s1_tick_r - cur_tick;
  assign fire     = armed_r && (CMP_W'(dur) > CMP_W'(long_press_r));
  assign wr_en    = s1_valid_r && s1_hit_r;
  assign wr_ent   = {nxt_st, nxt_tick};
  assign res_push = wr_en && release_hit;
  assign res_data = {fire, dur, s1_tick_r, s1_key_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
      armed_r  <= 1'b1;
    end else begin
      wb_vld_r <= wr_en;
      if (res_push && fire) begin
        armed_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_key_r <= s1_key_r;
      wb_ent_r <= wr_ent;
    end
  end

  // output queue
  assign fifo_pop = out_tvalid && out_tready;

  kdpt_out_fifo #(
    .DATA_W (OUT_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .pop       (fifo_pop),
    .pop_data  (fifo_q),
    .stat      (fifo_stat)
  );

  assign out_tvalid = fifo_stat.not_empty;
  assign out_tdata  = OUT_TW'(fifo_q);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (({1'b0, fifo_stat.used} + (FIFO_AW+2)'(s1_valid_r)) <= (FIFO_AW+2)'(FIFO_DEPTH)))
    else $error("output queue overcommitted");

  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted sample missing from read stage");

  a_marker_once: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |=> !armed_r)
    else $error("start marker rearmed without reset");

  a_marker_fires: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && fire) |=> !armed_r)
    else $error("marker fired but stayed armed");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import kdpt_pkg::*;

  localparam int SAMPLE_W    = 40;
  localparam int RELEASE_W   = 72;
  localparam int PHASE_WORDS = 310;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_AW-1:0] LONG_PRESS_ADDR = CFG_AW'({REG_LONG_PRESS, 2'b00});

  // lowest bits first: key, level, tick
  typedef struct packed {
    logic [31:0] tick;
    logic        level;
    logic [1:0]  key;
  } sample_t;

  // lowest bits first: key, release tick, duration, marker
  typedef struct packed {
    logic        marker;
    logic [31:0] dur;
    logic [31:0] tick;
    logic [1:0]  key;
  } release_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic [SAMPLE_W-1:0]  in_tdata   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [RELEASE_W-1:0] out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [CFG_AW-1:0]    paddr      = '0;
  logic [CFG_W-1:0]     pwdata     = '0;
  logic [CFG_W-1:0]     prdata;
  logic                 pready;

  sample_t     sample_q[$];
  release_t    release_q[$];
  sample_t     offered;

  key_state_t  key_phase[4];
  logic [31:0] press_mark[4];
  logic        marker_armed;
  logic [31:0] long_press_limit;

  bit          level_goal[4];
  int          goal_hits[4];
  logic [31:0] tick_clock = '0;

  bit          src_gaps  = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          hold_req  = 1'b0;
  int          hold_left = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  key_debounce_press_timer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void step_key(input sample_t s);
    release_t r;
    case (key_phase[s.key])
      ST_UP: begin
        if (!s.level) key_phase[s.key] = ST_FALLING;
      end
      ST_FALLING: begin
        if (!s.level) begin
          key_phase[s.key]  = ST_DOWN;
          press_mark[s.key] = s.tick;
        end else begin
          key_phase[s.key] = ST_UP;
        end
      end
      ST_DOWN: begin
        if (s.level) key_phase[s.key] = ST_RISING;
      end
      default: begin
        if (!s.level) begin
          key_phase[s.key] = ST_DOWN;
        end else begin
          key_phase[s.key] = ST_UP;
          r.key    = s.key;
          r.tick   = s.tick;
          r.dur    = s.tick - press_mark[s.key];
          r.marker = marker_armed && (r.dur > long_press_limit);
          if (r.marker) marker_armed = 1'b0;
          release_q.push_back(r);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        key_phase[k]  = ST_UP;
        press_mark[k] = '1;
      end
      marker_armed     = 1'b1;
      long_press_limit = LONG_PRESS_RESET;
    end else begin
      if (in_tvalid && in_tready) step_key(offered);
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && !(src_gaps && $urandom_range(99) < 38)) begin
          offered = sample_q.pop_front();
          in_tdata  <= SAMPLE_W'(offered);
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    release_t got;
    release_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = release_t'(out_tdata[$bits(release_t)-1:0]);
        if (release_q.size() == 0) begin
          $error("unexpected release word: key %0d tick %0h", got.key, got.tick);
          fail_count++;
        end else begin
          want = release_q.pop_front();
          if (got.key !== want.key) begin
            $error("released_key mismatch: expected %0d, actual %0d", want.key, got.key);
            fail_count++;
          end
          if (got.tick !== want.tick) begin
            $error("release_tick mismatch: expected %0h, actual %0h", want.tick, got.tick);
            fail_count++;
          end
          if (got.dur !== want.dur) begin
            $error("press_ticks mismatch: expected %0h, actual %0h", want.dur, got.dur);
            fail_count++;
          end
          if (got.marker !== want.marker) begin
            $error("start_marker mismatch: expected %0d, actual %0d", want.marker, got.marker);
            fail_count++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(sink_gaps && $urandom_range(99) < 38);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_sample(input logic [1:0] k, input logic l, input logic [31:0] t);
    sample_t s;
    s.key   = k;
    s.level = l;
    s.tick  = t;
    sample_q.push_back(s);
  endtask

  // mostly clean press/release runs per key, with some bounce noise
  task automatic queue_random_samples(input int n);
    logic [1:0] k;
    logic       l;
    for (int i = 0; i < n; i++) begin
      k = 2'($urandom_range(3));
      if ($urandom_range(99) < 12) begin
        l = 1'($urandom_range(1));
      end else begin
        l = level_goal[k];
        goal_hits[k]++;
        if (goal_hits[k] >= 2 && $urandom_range(99) < 45) begin
          level_goal[k] = !level_goal[k];
          goal_hits[k]  = 0;
        end
      end
      case ($urandom_range(19))
        0:       tick_clock = $urandom;
        1, 2:    tick_clock += $urandom_range(400, 1200);
        default: tick_clock += $urandom_range(0, 300);
      endcase
      push_sample(k, l, tick_clock);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_tvalid || release_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_long_press(input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LONG_PRESS_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    long_press_limit = v;
    @(negedge clk);
  endtask

  initial begin : sequencer
    for (int k = 0; k < 4; k++) begin
      level_goal[k] = 1'b1;
      goal_hits[k]  = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // duration equal to threshold, rising bounce
    push_sample(2'd0, 1'b0, 32'd0);
    push_sample(2'd0, 1'b0, 32'd100);
    push_sample(2'd0, 1'b1, 32'd300);
    push_sample(2'd0, 1'b0, 32'd350);
    push_sample(2'd0, 1'b1, 32'd500);
    push_sample(2'd0, 1'b1, 32'd600);
    // falling bounce, short press
    push_sample(2'd1, 1'b0, 32'd5);
    push_sample(2'd1, 1'b1, 32'd6);
    push_sample(2'd1, 1'b0, 32'd7);
    push_sample(2'd1, 1'b0, 32'd10);
    push_sample(2'd1, 1'b1, 32'd11);
    push_sample(2'd1, 1'b1, 32'd200);
    // tick wrap
    push_sample(2'd2, 1'b0, 32'hFFFF_FFF0);
    push_sample(2'd2, 1'b0, 32'hFFFF_FFF8);
    push_sample(2'd2, 1'b1, 32'h0000_0000);
    push_sample(2'd2, 1'b1, 32'h0000_0010);
    push_sample(2'd3, 1'b0, 32'hFFFF_FFFF);
    push_sample(2'd3, 1'b0, 32'hFFFF_FFFF);
    wait_idle();

    write_long_press(32'hFFFF_FFFF);
    push_sample(2'd3, 1'b1, 32'h0000_0000);
    push_sample(2'd3, 1'b1, 32'hFFFF_FFFE);
    wait_idle();

    // first long release fires the marker, the next one is disarmed
    write_long_press(32'h0000_0000);
    push_sample(2'd1, 1'b0, 32'd20);
    push_sample(2'd1, 1'b0, 32'd20);
    push_sample(2'd1, 1'b1, 32'd20);
    push_sample(2'd1, 1'b1, 32'd21);
    push_sample(2'd2, 1'b0, 32'hFFFF_FFFF);
    push_sample(2'd2, 1'b0, 32'h0000_0000);
    push_sample(2'd2, 1'b1, 32'h8000_0000);
    push_sample(2'd2, 1'b1, 32'hFFFF_FFFF);
    wait_idle();

    // sink held off while the source keeps pushing
    write_long_press(32'hFFFF_FFFF);
    src_gaps = 1'b0;
    hold_req = 1'b1;
    queue_random_samples(PHASE_WORDS);
    wait_idle();
    src_gaps = 1'b1;

    write_long_press(32'h8000_0000);
    queue_random_samples(PHASE_WORDS);
    wait_idle();

    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    queue_random_samples(PHASE_WORDS);
    wait_idle();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;

    write_long_press($urandom);
    queue_random_samples(PHASE_WORDS);
    wait_idle();

    write_long_press(LONG_PRESS_RESET);
    queue_random_samples(PHASE_WORDS);
    wait_idle();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && release_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
